@@ rtl/hpg_pkg.sv @@
// ----------------------------------------------------------------------------
// hpg_pkg
// Shared types and constants of the Heap's-order permutation generator.
// ----------------------------------------------------------------------------
`default_nettype none

package hpg_pkg;

	localparam int IDX_W  = 3;
	localparam int VAL_W  = 16;
	localparam int POS_W  = 3;
	localparam int LEN_W  = 4;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	localparam logic [LEN_W-1:0] LEN_RESET = 4'd8;

	// register index, taken from paddr[2]
	localparam logic REG_PERM_LENGTH = 1'b0;

	// request codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_NEXT = 1'b1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic             req_type;
		logic [IDX_W-1:0] elem_index;
		logic [VAL_W-1:0] elem_value;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] value;
		logic             last_element;
		logic             final_perm;
		logic             exhausted;
	} result_t;

	// classified request as handed from front to back
	typedef struct packed {
		logic             is_load;
		logic             in_range;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] value;
	} cmd_t;

endpackage

`default_nettype wire

@@ rtl/hpg_front.sv @@
// ----------------------------------------------------------------------------
// hpg_front
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hpg_front import hpg_pkg::*; #(
	parameter int MAX_ELEMS = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	output logic       full,
	input  wire item_t item,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  wire logic  cmd_take
);

	cmd_t                   entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   push_ok;
	logic                   take;
	cmd_t                   new_cmd;

	assign full      = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign push_ok   = push && !full;
	assign take      = cmd_take && cmd_valid;
	assign cmd       = entry_q[rd_ptr_q];

	always_comb begin
		new_cmd.is_load  = (item.req_type == REQ_LOAD);
		new_cmd.in_range = (32'(item.elem_index) < MAX_ELEMS);
		new_cmd.idx      = item.elem_index;
		new_cmd.value    = item.elem_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			count_q <= count_q + QUEUE_CNT_W'(push_ok) - QUEUE_CNT_W'(take);
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			entry_q[wr_ptr_q] <= new_cmd;
		end
	end

endmodule

`default_nettype wire

@@ rtl/hpg_back.sv @@
// ----------------------------------------------------------------------------
// hpg_back
// Element store, per-level loop counters and the emit / advance sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module hpg_back import hpg_pkg::*; #(
	parameter int MAX_ELEMS  = 8,
	parameter int ELEM_WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [LEN_W-1:0] len,
	input  wire logic             restart,
	input  wire logic             cmd_valid,
	input  wire cmd_t             cmd,
	output logic                  cmd_take,
	input  wire logic             pop,
	output logic                  empty,
	output result_t               result
);

	localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
	localparam int CW = AW;
	localparam int NW = $clog2(MAX_ELEMS + 1);
	localparam int SW = (ELEM_WIDTH < VAL_W) ? ELEM_WIDTH : VAL_W;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_EMIT_RD = 7'b0000010,
		ST_EMIT_WR = 7'b0000100,
		ST_EXH     = 7'b0001000,
		ST_ADV_RD  = 7'b0010000,
		ST_ADV_WA  = 7'b0100000,
		ST_ADV_WB  = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	logic [SW-1:0]     mem [MAX_ELEMS];
	logic [MAX_ELEMS-1:0] vld_q;
	logic [CW-1:0]     cnt_q [MAX_ELEMS];
	logic              done_q, done_d;
	logic              fperm_q, fperm_d;
	logic [AW-1:0]     p_q, p_d;
	logic [NW-1:0]     k_q, k_d;
	logic [AW-1:0]     a_q, a_d;
	logic [AW-1:0]     b_q, b_d;
	logic [CW-1:0]     i_q, i_d;
	logic [SW-1:0]     rd_a_s1, rd_b_s1;
	logic              out_valid_q;
	result_t           out_q;

	logic [NW-1:0]     n;
	logic              final_now;
	logic              out_free;
	logic              out_load;
	result_t           out_next;
	logic              we;
	logic [AW-1:0]     wa;
	logic [SW-1:0]     wd;
	logic              re;
	logic [AW-1:0]     rd_a_addr, rd_b_addr;
	logic              cnt_we;
	logic [CW-1:0]     cnt_wd;
	logic              clear_cnt;
	logic [AW-1:0]     lvl_idx;
	logic [CW-1:0]     cur_cnt;
	logic [AW-1:0]     swap_a;
	logic              is_last;

	// zero means one, anything above the store size saturates
	always_comb begin
		if (len == '0) begin
			n = NW'(1);
		end else if (32'(len) > MAX_ELEMS) begin
			n = NW'(MAX_ELEMS);
		end else begin
			n = NW'(len);
		end
	end

	// last permutation when every active level sits on its final index
	always_comb begin
		final_now = 1'b1;
		for (int k = 2; k <= MAX_ELEMS; k++) begin
			if ((NW'(k) <= n) && (cnt_q[k-1] != CW'(k - 1))) begin
				final_now = 1'b0;
			end
		end
	end

	assign out_free = !out_valid_q || pop;
	assign empty    = !out_valid_q;
	assign result   = out_q;
	assign lvl_idx  = AW'(k_q - NW'(1));
	assign cur_cnt  = cnt_q[lvl_idx];
	assign is_last  = ((NW'(p_q) + NW'(1)) == n);

	// odd level swaps with element 0, even level with element i
	always_comb begin
		if (k_q[0]) begin
			swap_a = '0;
		end else if (NW'(cur_cnt) < k_q) begin
			swap_a = AW'(cur_cnt);
		end else begin
			swap_a = lvl_idx;
		end
	end

	always_comb begin
		state_d   = state_q;
		p_d       = p_q;
		k_d       = k_q;
		done_d    = done_q;
		fperm_d   = fperm_q;
		a_d       = a_q;
		b_d       = b_q;
		i_d       = i_q;
		cnt_we    = 1'b0;
		cnt_wd    = '0;
		clear_cnt = restart;
		cmd_take  = 1'b0;
		we        = 1'b0;
		wa        = a_q;
		wd        = rd_b_s1;
		re        = 1'b0;
		rd_a_addr = p_q;
		rd_b_addr = b_q;
		out_load  = 1'b0;
		out_next  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					if (cmd.is_load) begin
						we        = cmd.in_range;
						wa        = AW'(cmd.idx);
						wd        = SW'(cmd.value);
						clear_cnt = 1'b1;
						done_d    = 1'b0;
					end else if (done_q) begin
						state_d = ST_EXH;
					end else begin
						fperm_d = final_now;
						p_d     = '0;
						state_d = ST_EMIT_RD;
					end
				end
			end
			ST_EMIT_RD: begin
				re      = 1'b1;
				state_d = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				if (out_free) begin
					out_load              = 1'b1;
					out_next.position     = POS_W'(p_q);
					out_next.value        = VAL_W'(rd_a_s1);
					out_next.last_element = is_last;
					out_next.final_perm   = fperm_q;
					out_next.exhausted    = 1'b0;
					if (is_last) begin
						if (n == NW'(1)) begin
							done_d  = 1'b1;
							state_d = ST_IDLE;
						end else begin
							k_d     = NW'(2);
							state_d = ST_ADV_RD;
						end
					end else begin
						p_d     = p_q + AW'(1);
						state_d = ST_EMIT_RD;
					end
				end
			end
			ST_EXH: begin
				if (out_free) begin
					out_load           = 1'b1;
					out_next.exhausted = 1'b1;
					state_d            = ST_IDLE;
				end
			end
			ST_ADV_RD: begin
				re        = 1'b1;
				rd_a_addr = swap_a;
				rd_b_addr = lvl_idx;
				a_d       = swap_a;
				b_d       = lvl_idx;
				i_d       = cur_cnt;
				state_d   = ST_ADV_WA;
			end
			ST_ADV_WA: begin
				we      = 1'b1;
				wa      = a_q;
				wd      = rd_b_s1;
				state_d = ST_ADV_WB;
			end
			ST_ADV_WB: begin
				we     = 1'b1;
				wa     = b_q;
				wd     = rd_a_s1;
				cnt_we = 1'b1;
				if ((NW'(i_q) + NW'(1)) < k_q) begin
					cnt_wd  = i_q + CW'(1);
					state_d = ST_IDLE;
				end else begin
					cnt_wd = '0;
					if (k_q == n) begin
						done_d  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						k_d     = k_q + NW'(1);
						state_d = ST_ADV_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (restart) begin
			done_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			fperm_q     <= 1'b0;
			p_q         <= '0;
			k_q         <= '0;
			a_q         <= '0;
			b_q         <= '0;
			i_q         <= '0;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
			for (int j = 0; j < MAX_ELEMS; j++) begin
				cnt_q[j] <= '0;
			end
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			fperm_q <= fperm_d;
			p_q     <= p_d;
			k_q     <= k_d;
			a_q     <= a_d;
			b_q     <= b_d;
			i_q     <= i_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (we) begin
				vld_q[wa] <= 1'b1;
			end
			if (clear_cnt) begin
				for (int j = 0; j < MAX_ELEMS; j++) begin
					cnt_q[j] <= '0;
				end
			end else if (cnt_we) begin
				cnt_q[b_q] <= cnt_wd;
			end
		end
	end

	// element store: one write, two registered reads; unwritten entries read as zero
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_a_s1 <= vld_q[rd_a_addr] ? mem[rd_a_addr] : '0;
			rd_b_s1 <= vld_q[rd_b_addr] ? mem[rd_b_addr] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_next;
		end
	end

endmodule

`default_nettype wire

@@ rtl/heap_permutation_generator_core.sv @@
// ----------------------------------------------------------------------------
// heap_permutation_generator_core
// Steps through all permutations of a loaded element array in Heap's order.
// ----------------------------------------------------------------------------
// requests enter through push/full into a two-entry queue; results leave
// through empty/pop from a single output register
// a load request writes one element (when its index is in range) and
// restarts the enumeration; it gives no result
// a next request gives one result per position (n of them, n = perm_length
// clamped to 1..MAX_ELEMS): each element is read through the element store's
// registered read port and then emitted; after the last element the
// sequencer advances, with one read and two writes on the store's single
// write port per level climbed
// once exhausted, a next request gives one result flagged exhausted
// the first result is read from the store, then loaded into the output register
// writing perm_length over the apb port restarts the enumeration and keeps
// the elements; writes belong to idle periods only
// reset clears the elements to zero, perm_length to 8, and empties both sides
// while pop stays low the sequencer holds its next result; the queue still
// takes requests until it is full
// ----------------------------------------------------------------------------
`default_nettype none

module heap_permutation_generator_core import hpg_pkg::*; #(
	parameter int MAX_ELEMS  = 8,
	parameter int ELEM_WIDTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire item_t             item,
	output logic                   empty,
	input  wire logic              pop,
	output result_t                result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	logic [LEN_W-1:0] len_q;
	logic             cfg_wr;
	logic             len_sel;
	logic             cmd_valid;
	logic             cmd_take;
	cmd_t             cmd;

	assign pready  = 1'b1;
	assign len_sel = (paddr[2] == REG_PERM_LENGTH);
	assign cfg_wr  = psel && penable && pwrite && pready && len_sel;
	assign prdata  = (psel && len_sel) ? DATA_W'(len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (cfg_wr) begin
			len_q <= pwdata[LEN_W-1:0];
		end
	end

	hpg_front #(
		.MAX_ELEMS (MAX_ELEMS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	hpg_back #(
		.MAX_ELEMS  (MAX_ELEMS),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.len       (len_q),
		.restart   (cfg_wr),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

`default_nettype wire

@@ rtl/hpg_checker.sv @@
// ----------------------------------------------------------------------------
// hpg_checker
// Port-level checks on the result side of the permutation generator.
// ----------------------------------------------------------------------------
`default_nettype none

module hpg_checker import hpg_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    empty,
	input wire logic    pop,
	input wire result_t result
);

	// a waiting result holds until its transfer
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed or vanished before its transfer");

	// the first reset edge may still see an unknown output register
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> empty)
		else $error("result shown during reset");

	a_exhausted_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.exhausted) |->
		(result.position == '0 && result.value == '0 &&
		 !result.last_element && !result.final_perm))
		else $error("exhausted result carries data");

	// within a permutation the next element follows with the next position
	a_perm_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !result.last_element && !result.exhausted) |=>
		(empty || (result.position == POS_W'($past(result.position) + 1) &&
		           result.final_perm == $past(result.final_perm) &&
		           !result.exhausted)))
		else $error("permutation element out of sequence");

endmodule

bind heap_permutation_generator_core hpg_checker u_hpg_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

`default_nettype wire
